>>> hw/rtl/ujs_pkg.sv
// Shared types, constants and the code point check for the UTF-8 JSON sanitizer.
package ujs_pkg;

  localparam int unsigned DefQueueDepth = 4;

  localparam logic [7:0] ByteNul = 8'h00;
  localparam logic [7:0] ByteTab = 8'h09;
  localparam logic [7:0] ByteLf  = 8'h0A;
  localparam logic [7:0] ByteCr  = 8'h0D;
  localparam logic [7:0] ByteSp  = 8'h20;

  localparam logic [2:0] LenNone = 3'd0;
  localparam logic [2:0] LenOne  = 3'd1;
  localparam logic [2:0] LenTwo  = 3'd2;
  localparam logic [2:0] LenThree = 3'd3;
  localparam logic [2:0] LenFour = 3'd4;

  // One group of bytes to emit; byte 0 goes out first.
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      len;
  } group_t;

  function automatic logic [2:0] lead_len(input logic [7:0] b);
    logic [2:0] r;
    r = LenNone;
    if (b[7] == 1'b0) r = LenOne;
    else if (b[7:5] == 3'b110) r = LenTwo;
    else if (b[7:4] == 4'b1110) r = LenThree;
    else if (b[7:3] == 5'b11110) r = LenFour;
    return r;
  endfunction

  function automatic logic seq_ok(input logic [3:0][7:0] q, input logic [2:0] n);
    logic [20:0] cp;
    logic        ok;
    cp = '0;
    ok = 1'b0;
    case (n)
      LenTwo: begin
        cp = {10'd0, q[0][4:0], q[1][5:0]};
        ok = (cp >= 21'h80);
      end
      LenThree: begin
        cp = {5'd0, q[0][3:0], q[1][5:0], q[2][5:0]};
        ok = (cp >= 21'h800) && !((cp >= 21'hD800) && (cp <= 21'hDFFF));
      end
      LenFour: begin
        cp = {q[0][2:0], q[1][5:0], q[2][5:0], q[3][5:0]};
        ok = (cp >= 21'h10000) && (cp <= 21'h10FFFF);
      end
      default: ok = 1'b0;
    endcase
    return ok;
  endfunction

endpackage

>>> hw/rtl/ujs_front.sv
// Front end: takes one byte per cycle, tracks open sequences, pushes byte groups.
module ujs_front import ujs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       req_i,
  input  logic [7:0] byte_i,
  output logic       push_o,
  output group_t     group_o
);

  logic [2:0]      exp_q, exp_d;
  logic [2:0]      cnt_q, cnt_d;
  logic [7:0]      held_q [3];
  logic            hold_we;
  logic [1:0]      hold_idx;
  logic [3:0][7:0] seq;
  logic [2:0]      lead;
  logic            examine;

  always_comb begin
    exp_d    = exp_q;
    cnt_d    = cnt_q;
    hold_we  = 1'b0;
    hold_idx = 2'd0;
    push_o   = 1'b0;
    group_o  = '0;
    examine  = 1'b0;
    lead     = lead_len(byte_i);
    seq      = '0;
    seq[0]   = held_q[0];
    seq[1]   = (cnt_q == LenOne) ? byte_i : held_q[1];
    seq[2]   = (cnt_q == LenTwo) ? byte_i : held_q[2];
    seq[3]   = byte_i;
    if (req_i) begin
      if (byte_i == ByteNul) begin
        exp_d = LenNone;
        cnt_d = LenNone;
        push_o = 1'b1;
        group_o.len = LenOne;
      end else if (exp_q != LenNone && byte_i[7:6] == 2'b10) begin
        if (cnt_q + 3'd1 == exp_q) begin
          exp_d = LenNone;
          cnt_d = LenNone;
          if (seq_ok(seq, exp_q)) begin
            push_o = 1'b1;
            group_o.bytes = seq;
            group_o.len = exp_q;
          end
        end else begin
          hold_we  = 1'b1;
          hold_idx = cnt_q[1:0];
          cnt_d    = cnt_q + 3'd1;
        end
      end else begin
        exp_d   = LenNone;
        cnt_d   = LenNone;
        examine = 1'b1;
      end
      if (examine) begin
        if (lead == LenOne) begin
          if (byte_i >= ByteSp || byte_i == ByteLf || byte_i == ByteCr ||
              byte_i == ByteTab) begin
            push_o = 1'b1;
            group_o.bytes[0] = byte_i;
            group_o.len = LenOne;
          end
        end else if (lead != LenNone) begin
          hold_we  = 1'b1;
          hold_idx = 2'd0;
          cnt_d    = LenOne;
          exp_d    = lead;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_q <= LenNone;
      cnt_q <= LenNone;
    end else begin
      exp_q <= exp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (hold_we) begin
      held_q[hold_idx] <= byte_i;
    end
  end

endmodule

>>> hw/rtl/ujs_queue.sv
// Short FIFO of byte groups between front and back end.
module ujs_queue import ujs_pkg::*; #(
  parameter int unsigned Depth = DefQueueDepth
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  group_t group_i,
  input  logic   pop_i,
  output logic   full_o,
  output logic   empty_o,
  output group_t head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  group_t            mem_q [Depth];
  logic [PtrW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
    end
    if (do_push && !do_pop) cnt_d = cnt_q + CntW'(1);
    else if (do_pop && !do_push) cnt_d = cnt_q - CntW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= group_i;
    end
  end

endmodule

>>> hw/rtl/ujs_back.sv
// Back end: sends the head group out one byte per request, tlast on its final byte.
module ujs_back import ujs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       empty_i,
  input  group_t     head_i,
  output logic       pop_o,
  output logic       valid_o,
  input  logic       ready_i,
  output logic [7:0] data_o,
  output logic       last_o
);

  logic [1:0] idx_q, idx_d;
  logic       fire;

  assign valid_o = !empty_i;
  assign data_o  = head_i.bytes[idx_q];
  assign last_o  = ({1'b0, idx_q} + 3'd1 == head_i.len);
  assign fire    = valid_o && ready_i;
  assign pop_o   = fire && last_o;

  always_comb begin
    idx_d = idx_q;
    if (fire) begin
      idx_d = last_o ? 2'd0 : idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 2'd0;
    end else begin
      idx_q <= idx_d;
    end
  end

endmodule

>>> hw/rtl/utf8_json_sanitizer_top.sv
// Top level of the UTF-8 JSON sanitizer: front end, group queue, back end.
// Takes one byte per cycle on the slave side whenever the group queue
// (QueueDepth entries) has room; accepted bytes are checked in the same
// cycle and every kept character is queued as one group of 1 to 4 bytes.
// The master side delivers one byte per cycle while m_axis_tready_i is high
// and the queue is not empty, tlast marking the final byte of each group.
// A complete character is written into the group queue when its final byte
// is taken, and is offered on the master side once it reaches the head.
module utf8_json_sanitizer_top import ujs_pkg::*; #(
  parameter int unsigned QueueDepth = DefQueueDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] in_byte
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] out_byte
  output logic       m_axis_tlast_o    // last_of_run
);

  logic   push, pop, full, empty;
  group_t grp, head;

  assign s_axis_tready_o = !full;

  ujs_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (s_axis_tvalid_i && !full),
    .byte_i  (s_axis_tdata_i),
    .push_o  (push),
    .group_o (grp)
  );

  ujs_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .group_i (grp),
    .pop_i   (pop),
    .full_o  (full),
    .empty_o (empty),
    .head_o  (head)
  );

  ujs_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .head_i  (head),
    .pop_o   (pop),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .data_o  (m_axis_tdata_o),
    .last_o  (m_axis_tlast_o)
  );

endmodule
